// File: src/thsl_pkg.sv
// ----------------------------------------------------------------------------
// thsl_pkg: shared types of the triangle hyperplane slice
// Vertex and queue entry layouts used by the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none
package thsl_pkg;

	// x, y, z, w in Q16.16; index 0 is x, index 3 is w
	typedef logic [3:0][31:0] vertex_t;

	// one triangle waiting for the back: corners a, b, c in slots 0, 1, 2
	typedef struct packed {
		vertex_t [2:0] vert;
		logic          batch_end;
	} tri_t;

	localparam int CoordW = 32;

endpackage
`default_nettype wire

// File: src/thsl_ram.sv
// ----------------------------------------------------------------------------
// thsl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds when
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none
module thsl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/thsl_front.sv
// ----------------------------------------------------------------------------
// thsl_front: item intake and vertex store
// Writes load items into the store and gathers the three corners of a slice
// item over three reads, then pushes the triangle into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module thsl_front #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          mode,
	input  wire logic [9:0]    slot,
	input  wire logic [31:0]   coord_x,
	input  wire logic [31:0]   coord_y,
	input  wire logic [31:0]   coord_z,
	input  wire logic [31:0]   coord_w,
	input  wire logic [9:0]    corner_a,
	input  wire logic [9:0]    corner_b,
	input  wire logic [9:0]    corner_c,
	input  wire logic          batch_end,
	input  wire logic          q_full,
	output logic               q_push,
	output thsl_pkg::tri_t     q_data
);
	import thsl_pkg::*;

	localparam int AW = $clog2(VERTEX_SLOTS);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_A    = 2'd1;
	localparam logic [1:0] PH_B    = 2'd2;
	localparam logic [1:0] PH_C    = 2'd3;

	logic [1:0]    phase_q;
	logic [9:0]    cb_q, cc_q;
	logic          bend_q;
	vertex_t       va_q, vb_q;
	logic          oor_q;
	logic          accept;
	logic          we, re;
	logic [9:0]    rsel;
	logic [16:0]   wext, rext;
	logic [AW-1:0] waddr, raddr;
	vertex_t       rdata, rvert;

	assign in_stall = (phase_q != PH_IDLE);
	assign accept   = in_valid && !in_stall;

	// store address decode with range check
	assign wext  = {7'd0, slot};
	assign waddr = wext[AW-1:0];
	assign we    = accept && !mode && (wext < 17'(VERTEX_SLOTS));

	always_comb begin
		unique case (phase_q)
			PH_A:    rsel = cb_q;
			PH_B:    rsel = cc_q;
			default: rsel = corner_a;
		endcase
	end
	assign rext  = {7'd0, rsel};
	assign raddr = rext[AW-1:0];
	assign re    = (accept && mode) || (phase_q == PH_A) || (phase_q == PH_B);

	thsl_ram #(
		.WIDTH(4 * CoordW),
		.DEPTH(VERTEX_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({coord_w, coord_z, coord_y, coord_x}),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// out-of-range corners read as the origin
	assign rvert = oor_q ? '0 : rdata;

	assign q_push = (phase_q == PH_C) && !q_full;
	assign q_data = '{vert: {rvert, vb_q, va_q}, batch_end: bend_q};

	// sequence the three corner reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: if (accept && mode) phase_q <= PH_A;
				PH_A:    phase_q <= PH_B;
				PH_B:    phase_q <= PH_C;
				default: if (q_push) phase_q <= PH_IDLE;
			endcase
		end
	end

	// capture corners and item fields
	always_ff @(posedge clk) begin
		if (re) begin
			oor_q <= !(rext < 17'(VERTEX_SLOTS));
		end
		if (accept && mode) begin
			cb_q   <= corner_b;
			cc_q   <= corner_c;
			bend_q <= batch_end;
		end
		if (phase_q == PH_A) va_q <= rvert;
		if (phase_q == PH_B) vb_q <= rvert;
	end

endmodule
`default_nettype wire

// File: src/thsl_queue.sv
// ----------------------------------------------------------------------------
// thsl_queue: two-entry triangle queue
// Decouples corner gathering from edge cutting.
// ----------------------------------------------------------------------------
`default_nettype none
module thsl_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire thsl_pkg::tri_t wdata,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output thsl_pkg::tri_t     rdata
);
	import thsl_pkg::*;

	tri_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

// File: src/thsl_back.sv
// ----------------------------------------------------------------------------
// thsl_back: edge cutter
// Classifies each edge of the head triangle; for each hit edge off the plane
// it multiplies and divides one coordinate at a time, and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module thsl_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    slice_w,
	input  wire logic           q_empty,
	input  wire thsl_pkg::tri_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [31:0]         point_x,
	output logic [31:0]         point_y,
	output logic [31:0]         point_z,
	output logic                point_valid,
	output logic [1:0]          edge_index,
	output logic                last,
	output logic                batch_done
);
	import thsl_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLS   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_ACC   = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]        state_q;
	logic [1:0]        edge_q, k_q;
	logic [2:0]        mask_q, mask_nx, ebit;
	logic              emitted_q, nohit_q;
	logic [4:0]        step_q;
	logic [31:0]       num_mag_q, den_mag_q;
	logic              sign_q, neg_q;
	logic [63:0]       pr_q;
	logic [2:0][31:0]  pt_q;
	logic              out_free;

	vertex_t     sv, ev;
	logic [1:0]  eidx;
	logic [32:0] num, den, num_abs, den_abs, dd, dd_abs;
	logic        hit;
	logic [32:0] r2, diff;
	logic        ge;
	logic [63:0] prod;
	logic [31:0] qv;

	// edge endpoints
	assign eidx = (edge_q == 2'd2) ? 2'd0 : edge_q + 2'd1;
	assign sv   = q_data.vert[edge_q];
	assign ev   = q_data.vert[eidx];

	// hit test of the current edge
	assign num     = {slice_w[31], slice_w} - {sv[3][31], sv[3]};
	assign den     = {ev[3][31], ev[3]} - {sv[3][31], sv[3]};
	assign num_abs = num[32] ? (~num + 33'd1) : num;
	assign den_abs = den[32] ? (~den + 33'd1) : den;
	assign hit     = (den == 33'd0) ? (num == 33'd0)
	               : (((num == 33'd0) || (num[32] == den[32])) && (num_abs <= den_abs));

	// coordinate difference and product
	assign dd     = {ev[k_q][31], ev[k_q]} - {sv[k_q][31], sv[k_q]};
	assign dd_abs = dd[32] ? (~dd + 33'd1) : dd;
	assign prod   = num_mag_q * dd_abs[31:0];

	// one restoring division step
	assign r2   = pr_q[63:31];
	assign diff = r2 - {1'b0, den_mag_q};
	assign ge   = (r2 >= {1'b0, den_mag_q});
	assign qv   = neg_q ? (~pr_q[31:0] + 32'd1) : pr_q[31:0];

	assign ebit     = 3'b001 << edge_q;
	assign mask_nx  = mask_q & ~ebit;
	assign out_free = !out_valid || !out_stall;
	assign q_pop    = ((state_q == S_SCAN) && (mask_q == 3'd0) && emitted_q)
	               || ((state_q == S_EMIT) && out_free && nohit_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			edge_q    <= 2'd0;
			k_q       <= 2'd0;
			mask_q    <= 3'd0;
			emitted_q <= 1'b0;
			nohit_q   <= 1'b0;
			step_q    <= 5'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					edge_q    <= 2'd0;
					emitted_q <= 1'b0;
					nohit_q   <= 1'b0;
					if (!q_empty) state_q <= S_CLS;
				end
				S_CLS: begin
					mask_q[edge_q] <= hit;
					if (edge_q == 2'd2) begin
						edge_q  <= 2'd0;
						state_q <= S_SCAN;
					end else begin
						edge_q <= edge_q + 2'd1;
					end
				end
				S_SCAN: begin
					if (mask_q == 3'd0) begin
						if (emitted_q) begin
							state_q <= S_IDLE;
						end else begin
							nohit_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end else if (mask_q[edge_q]) begin
						state_q <= S_SETUP;
					end else begin
						edge_q <= edge_q + 2'd1;
					end
				end
				S_SETUP: begin
					k_q     <= 2'd0;
					state_q <= (den == 33'd0) ? S_EMIT : S_MUL;
				end
				S_MUL: begin
					step_q  <= 5'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) state_q <= S_ACC;
				end
				S_ACC: begin
					if (k_q == 2'd2) begin
						state_q <= S_EMIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				default: begin
					if (out_free) begin
						emitted_q <= 1'b1;
						mask_q    <= mask_nx;
						state_q   <= nohit_q ? S_IDLE : S_SCAN;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN: begin
				if (mask_q == 3'd0) pt_q <= '0;
			end
			S_SETUP: begin
				num_mag_q <= num_abs[31:0];
				den_mag_q <= den_abs[31:0];
				sign_q    <= num[32] ^ den[32];
				pt_q      <= {sv[2], sv[1], sv[0]};
			end
			S_MUL: begin
				pr_q  <= prod;
				neg_q <= sign_q ^ dd[32];
			end
			S_DIV: begin
				pr_q <= {ge ? diff[31:0] : r2[31:0], pr_q[30:0], ge};
			end
			S_ACC: begin
				pt_q[k_q] <= sv[k_q] + qv;
			end
			default: ;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			point_x     <= pt_q[0];
			point_y     <= pt_q[1];
			point_z     <= pt_q[2];
			point_valid <= !nohit_q;
			edge_index  <= nohit_q ? 2'd0 : edge_q;
			last        <= nohit_q || (mask_nx == 3'd0);
			batch_done  <= (nohit_q || (mask_nx == 3'd0)) && q_data.batch_end;
		end
	end

endmodule
`default_nettype wire

// File: src/triangle_hyperplane_slice.sv
// ----------------------------------------------------------------------------
// triangle_hyperplane_slice: cut 4D triangles with the plane w = slice_w
// Vertex store, corner gathering, triangle queue and edge cutter.
// ----------------------------------------------------------------------------
// A load item is taken without stalling the intake. A slice item stalls the
// intake while its three corners are read one after another through the
// single store read port, and longer while the queue is full; it then waits
// in a two-entry queue. The edge cutter picks up the head triangle and
// classifies its edges one by one. Each hit edge then goes through a scan
// step, a setup step and, per coordinate, a multiply step, a divide in a
// one-bit-per-cycle divider and an accumulate step, then an emit step. An
// edge lying in the plane skips the arithmetic, a skipped edge ahead of a
// hit one adds a scan step, and one closing scan step releases the triangle.
// A triangle with no hit emits one no-hit result and is released at its
// emit step. Output stalls hold the cutter in its emit step.
// Results leave through an output register.
`default_nettype none
module triangle_hyperplane_slice #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        slice_w_we,
	input  wire logic [31:0] slice_w_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [9:0]  slot,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [31:0] coord_z,
	input  wire logic [31:0] coord_w,
	input  wire logic [9:0]  corner_a,
	input  wire logic [9:0]  corner_b,
	input  wire logic [9:0]  corner_c,
	input  wire logic        batch_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      point_x,
	output logic [31:0]      point_y,
	output logic [31:0]      point_z,
	output logic             point_valid,
	output logic [1:0]       edge_index,
	output logic             last,
	output logic             batch_done
);
	import thsl_pkg::*;

	logic [31:0] slice_w_q;
	logic        q_full, q_push, q_empty, q_pop;
	tri_t        q_wdata, q_rdata;

	// slicing plane register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_w_q <= 32'd0;
		end else if (slice_w_we) begin
			slice_w_q <= slice_w_data;
		end
	end

	thsl_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.slot     (slot),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.coord_z  (coord_z),
		.coord_w  (coord_w),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c),
		.batch_end(batch_end),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	thsl_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.empty (q_empty),
		.rdata (q_rdata)
	);

	thsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slice_w    (slice_w_q),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.point_valid(point_valid),
		.edge_index (edge_index),
		.last       (last),
		.batch_done (batch_done)
	);

	// a no-hit result closes its triangle, has edge index 0 and a zero point_x
	a_nohit_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> last && (edge_index == 2'd0) && (point_x == 32'd0))
		else $error("no-hit result malformed");

	// batch end only on the last result of a triangle
	a_batch_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && batch_done |-> last)
		else $error("batch_done without last");

	// edge index stays within the edges of a triangle
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (edge_index != 2'd3))
		else $error("edge index out of range");

	// queue never pops while empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: tb/sv/triangle_hyperplane_slice_tb.sv
// ----------------------------------------------------------------------------
// triangle_hyperplane_slice_tb: self-checking bench for the hyperplane slicer
// Loads vertices, slices triangles under several plane settings, and compares
// every emitted point against an in-bench edge cutter with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_hyperplane_slice_tb;

	localparam int SLOTS = 1024;
	localparam int WDOG_LIMIT = 20000;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SLICE = 1'b1;

	typedef struct {
		logic        mode;
		logic [9:0]  slot;
		logic [31:0] cx, cy, cz, cw;
		logic [9:0]  ca, cb, cc;
		logic        bend;
	} item_t;

	typedef struct packed {
		logic [31:0] px, py, pz;
		logic        pv;
		logic [1:0]  eidx;
		logic        lst;
		logic        bdone;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic slice_w_we = 0;
	logic [31:0] slice_w_data = 0;
	logic in_valid = 0;
	logic mode = 0;
	logic [9:0] slot = 0;
	logic [31:0] coord_x = 0, coord_y = 0, coord_z = 0, coord_w = 0;
	logic [9:0] corner_a = 0, corner_b = 0, corner_c = 0;
	logic batch_end = 0;
	logic out_stall = 0;
	logic in_stall, out_valid, point_valid, last, batch_done;
	logic [31:0] point_x, point_y, point_z;
	logic [1:0] edge_index;

	triangle_hyperplane_slice dut (
		.clk(clk), .arst_n(arst_n),
		.slice_w_we(slice_w_we), .slice_w_data(slice_w_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .slot(slot),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_w(coord_w),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.batch_end(batch_end), .out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.point_valid(point_valid), .edge_index(edge_index), .last(last),
		.batch_done(batch_done)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic signed [31:0] vstore [SLOTS][4];
	bit                 loaded [SLOTS];
	logic signed [31:0] plane_w;
	point_t             pending_pts [$];
	item_t              dir_rows [$];
	int                 dir_nexp [$];
	point_t             dir_points [$];
	int                 errors = 0;
	int                 idle_cycles = 0;
	int                 last_count = 0;
	bit                 sending_done = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// cut one edge s-e by the plane; returns 1 on hit
	function automatic bit cut_edge(input logic signed [31:0] s[4],
			input logic signed [31:0] e[4], output logic [31:0] p[3]);
		logic signed [33:0] num, den, dk;
		logic signed [67:0] prod, q;
		num = 34'(plane_w) - 34'(s[3]);
		den = 34'(e[3]) - 34'(s[3]);
		if (den == 0) begin
			if (num != 0) return 0;
			for (int k = 0; k < 3; k++) p[k] = s[k];
			return 1;
		end
		if (num != 0 && ((num > 0) != (den > 0))) return 0;
		if ((num < 0 ? -num : num) > (den < 0 ? -den : den)) return 0;
		for (int k = 0; k < 3; k++) begin
			dk = 34'(e[k]) - 34'(s[k]);
			prod = 68'(num) * 68'(dk);
			q = prod / 68'(den);
			p[k] = 32'(68'(s[k]) + q);
		end
		return 1;
	endfunction

	// apply one accepted item to the predictor state
	task automatic predict_item(input item_t it);
		logic signed [31:0] v[3][4];
		logic [9:0] idx[3];
		logic [31:0] p[3];
		point_t r;
		int n;
		if (it.mode == MODE_LOAD) begin
			vstore[it.slot] = '{it.cx, it.cy, it.cz, it.cw};
			loaded[it.slot] = 1;
			last_count = 0;
			return;
		end
		idx = '{it.ca, it.cb, it.cc};
		for (int c = 0; c < 3; c++) v[c] = vstore[idx[c]];
		n = 0;
		for (int ed = 0; ed < 3; ed++) begin
			if (cut_edge(v[ed], v[(ed + 1) % 3], p)) begin
				r = '{p[0], p[1], p[2], 1'b1, 2'(ed), 1'b0, 1'b0};
				pending_pts.insert(pending_pts.size(), r);
				n++;
			end
		end
		if (n == 0) begin
			r = '{32'd0, 32'd0, 32'd0, 1'b0, 2'd0, 1'b0, 1'b0};
			pending_pts.insert(pending_pts.size(), r);
			n = 1;
		end
		pending_pts[$].lst = 1;
		pending_pts[$].bdone = it.bend;
		last_count = n;
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// drive one item and wait for acceptance
	task automatic send_item(input item_t it, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		// drop valid only across a gap so back-to-back items keep it high
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		mode <= it.mode; slot <= it.slot;
		coord_x <= it.cx; coord_y <= it.cy; coord_z <= it.cz; coord_w <= it.cw;
		corner_a <= it.ca; corner_b <= it.cb; corner_c <= it.cc;
		batch_end <= it.bend;
		do @(posedge clk); while (in_stall);
		predict_item(it);
	endtask

	task automatic set_plane(input logic [31:0] w);
		in_valid <= 0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		slice_w_we <= 1;
		slice_w_data <= w;
		@(posedge clk);
		slice_w_we <= 0;
		plane_w = w;
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t load_row(input logic [9:0] s, input logic [31:0] x, y, z, w);
		return '{MODE_LOAD, s, x, y, z, w, 10'($urandom), 10'($urandom), 10'($urandom),
			1'($urandom)};
	endfunction

	function automatic item_t slice_row(input logic [9:0] a, b, c, input logic be);
		return '{MODE_SLICE, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
			a, b, c, be};
	endfunction

	function automatic logic [9:0] loaded_slot();
		logic [9:0] s;
		do s = 10'($urandom); while (!loaded[s]);
		return s;
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			idle_cycles <= 0;
			if (pending_pts.size() == 0) begin
				report_mismatch("unexpected result", point_x, 32'd0);
			end else begin
				point_t w;
				w = pending_pts.pop_front();
				if (point_x !== w.px) report_mismatch("point_x", point_x, w.px);
				if (point_y !== w.py) report_mismatch("point_y", point_y, w.py);
				if (point_z !== w.pz) report_mismatch("point_z", point_z, w.pz);
				if (point_valid !== w.pv)
					report_mismatch("point_valid", 32'(point_valid), 32'(w.pv));
				if (edge_index !== w.eidx)
					report_mismatch("edge_index", 32'(edge_index), 32'(w.eidx));
				if (last !== w.lst)
					report_mismatch("last", 32'(last), 32'(w.lst));
				if (batch_done !== w.bdone)
					report_mismatch("batch_done", 32'(batch_done), 32'(w.bdone));
			end
		end else if (arst_n && in_valid && !in_stall) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stall the result side at random, with quiet stretches
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g != 0) begin
				out_stall <= 1;
				repeat (g) @(posedge clk);
				out_stall <= 0;
			end
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// end the run when nothing moves for too long
	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] planes[5];
		point_t      t, w;
		planes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0};
		plane_w = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, edge in plane, no hit, batch end, limit slots
		dir_rows.insert(dir_rows.size(), load_row(10'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd0, 32'h8000_0000));
		dir_rows.insert(dir_rows.size(), load_row(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'h7FFF_FFFF));
		dir_rows.insert(dir_rows.size(), load_row(10'd2, 32'h0001_0000, 32'h0002_0000,
			32'h0003_0000, 32'h0));
		dir_rows.insert(dir_rows.size(), load_row(10'd3, 32'h0005_0000, 32'h0006_0000,
			32'h0007_0000, 32'h0));
		dir_rows.insert(dir_rows.size(), load_row(10'd4, 32'h1, 32'h2, 32'h3,
			32'h0001_0000));
		dir_rows.insert(dir_rows.size(), slice_row(10'd0, 10'd1023, 10'd4, 1'b0));
		dir_rows.insert(dir_rows.size(), slice_row(10'd4, 10'd4, 10'd4, 1'b1));
		dir_rows.insert(dir_rows.size(), slice_row(10'd2, 10'd3, 10'd2, 1'b1));
		dir_rows.insert(dir_rows.size(), slice_row(10'd1023, 10'd0, 10'd1023, 1'b0));
		// results typed in per row; zero leaves the row to the predictor
		dir_nexp = '{0, 0, 0, 0, 0, 0, 1, 3, 0};
		dir_points = '{
			// degenerate triangle at w=1.0 with plane 0: no hit
			'{32'd0, 32'd0, 32'd0, 1'b0, 2'd0, 1'b1, 1'b1},
			// all-zero w triangle at plane 0: every edge lies in the plane, emits starts
			'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1, 2'd0, 1'b0, 1'b0},
			'{32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 1'b1, 2'd1, 1'b0, 1'b0},
			'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1, 2'd2, 1'b1, 1'b1}};
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i], 0);
			if (dir_nexp[i] != 0 && last_count != dir_nexp[i])
				report_mismatch("directed count", 32'(last_count), 32'(dir_nexp[i]));
			for (int k = 0; k < dir_nexp[i]; k++) begin
				w = dir_points.pop_front();
				if (k < last_count) begin
					t = pending_pts[pending_pts.size() - last_count + k];
					if (t != w)
						report_mismatch("directed point", t.px, w.px);
				end
			end
		end

		// random phases under several plane settings
		foreach (planes[ph]) begin
			set_plane(planes[ph]);
			repeat (90) begin
				item_t it;
				if ($urandom_range(0, 2) == 0)
					it = load_row(10'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
						($urandom_range(0, 1)) ? plane_w + 32'($urandom_range(0, 6)) - 32'd3
							: rnd_coord());
				else
					it = slice_row(loaded_slot(), loaded_slot(), loaded_slot(),
						1'($urandom));
				send_item(it, 1);
			end
		end
		in_valid <= 0;

		while (pending_pts.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
src/thsl_pkg.sv
src/thsl_ram.sv
src/thsl_front.sv
src/thsl_queue.sv
src/thsl_back.sv
src/triangle_hyperplane_slice.sv
tb/sv/triangle_hyperplane_slice_tb.sv
